### rtl/csi_fwu_pkg.sv
// Shared types, constants and field-extraction functions for the CSI float word unpacker.
// Used by every module under rtl; has no dependencies of its own.
package csi_fwu_pkg;

    localparam int NUM_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(NUM_ENTRIES);
    localparam int INDEX_W     = 8;
    localparam int WORD_W      = 32;
    localparam int DATA_W      = 32;
    localparam int MAX_W       = 9;
    localparam int SHIFT_W     = 10;
    localparam int MAG_W       = 14;
    localparam int POS_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTOSCALE_ON  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MANTISSA_BITS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT_BITS = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [4:0] TARGET_BITS_RST   = 5'd10;
    localparam logic [3:0] MANTISSA_BITS_RST = 4'd12;
    localparam logic [3:0] EXPONENT_BITS_RST = 4'd6;

    typedef struct packed {
        logic [4:0] target_bits;
        logic       autoscale_on;
        logic [3:0] mantissa_bits;
        logic [3:0] exponent_bits;
    } t_cfg;

    // A 4-bit register never exceeds 15, so only the lower limit needs clamping.
    function automatic logic [3:0] man_width(input logic [3:0] m);
        logic [3:0] r;
        r = m;
        if (m < 4'd2) begin
            r = 4'd2;
        end
        return r;
    endfunction

    function automatic logic [3:0] exp_width(input logic [3:0] e);
        logic [3:0] r;
        r = e;
        if (e < 4'd2) begin
            r = 4'd2;
        end else if (e > 4'd8) begin
            r = 4'd8;
        end
        return r;
    endfunction

    function automatic logic signed [MAX_W-1:0] neg_half(input logic [3:0] ne);
        logic [9:0] full;
        full = 10'd0 - (10'd1 << (ne - 4'd1));
        return $signed(full[MAX_W-1:0]);
    endfunction

    function automatic logic signed [MAX_W-1:0] word_exponent(input logic [WORD_W-1:0] w,
                                                              input logic [3:0] ne);
        logic [7:0] mask;
        logic [7:0] raw;
        logic [9:0] full;
        mask = 8'((9'd1 << ne) - 9'd1);
        raw  = w[7:0] & mask;
        full = {2'b00, raw};
        if (raw[3'(ne - 4'd1)]) begin
            full = full - (10'd1 << ne);
        end
        return $signed(full[MAX_W-1:0]);
    endfunction

    function automatic logic [MAG_W-1:0] mag_field(input logic [WORD_W-1:0] w,
                                                   input logic [4:0] lsb,
                                                   input logic [3:0] nm);
        logic [14:0]       mask;
        logic [WORD_W-1:0] sh;
        mask = (15'd1 << (nm - 4'd1)) - 15'd1;
        sh   = w >> lsb;
        return MAG_W'(sh[14:0] & mask);
    endfunction

    function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (x[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

### rtl/csi_float_word_unpacker.sv
// Top level of the CSI shared-exponent float to fixed unpacker.
// Depends on csi_fwu_pkg, csi_fwu_store and csi_fwu_scale.
//
// Usage:
// The slave stream carries requests: tuser is the request kind (0 load, 1 read),
// tdata holds the entry index in bits 7:0 and the packed word in bits 39:8.
// A load stores the word and, with autoscale on, updates the frame maximum;
// a load at index 0 restarts that maximum. A load produces no transfer.
// A read produces one master transfer: I in tdata bits 31:0, Q in bits 63:32.
// Configuration registers are to be written by the user through the plain write
// port while the block is idle; the block does not enforce it. One request is
// accepted every cycle unless a stalled read holds tready low. The store read
// is registered at the accepting edge, then decoded into the output register.
// When the receiver stalls, one read result waits in the output register and
// one request more can sit in the decode stage; after that the slave tready
// drops until the receiver takes the result. Reset clears the pipeline valid
// bits and returns the frame maximum and the configuration registers to their
// reset values; the store contents are undefined until loaded.
module csi_float_word_unpacker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // index [7:0], packed_word [39:8]
    input  logic        i_s_axis_tuser,  // req_type [0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,  // in_phase [31:0], quadrature [63:32]
    input  logic                                  i_cfg_wr_en,
    input  logic [csi_fwu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [csi_fwu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import csi_fwu_pkg::*;

    t_cfg r_cfg;

    logic [INDEX_W-1:0] in_index;
    logic [WORD_W-1:0]  in_word;
    logic               in_accept;
    logic               in_oor;

    logic               r_s1_valid;
    logic               r_s1_req;
    logic               r_s1_oor;
    logic               r_s1_idx_zero;
    logic [WORD_W-1:0]  r_s1_load_word;
    logic [WORD_W-1:0]  rd_data;

    logic signed [MAX_W-1:0] r_max;
    logic signed [MAX_W-1:0] n_max;

    logic               r_out_valid;
    logic [63:0]        r_out_data;

    logic               out_free;
    logic               s1_adv;

    logic [WORD_W-1:0]         s1_word;
    logic [3:0]                nm;
    logic [3:0]                ne;
    logic [4:0]                q_lsb;
    logic [4:0]                i_lsb;
    logic [5:0]                si_pos;
    logic                      sign_i;
    logic                      sign_q;
    logic [MAG_W-1:0]          mag_i;
    logic [MAG_W-1:0]          mag_q;
    logic [MAG_W-1:0]          mag_or;
    logic signed [MAX_W-1:0]   exp_val;
    logic signed [MAX_W-1:0]   exp_top;
    logic signed [MAX_W-1:0]   half_neg;
    logic signed [MAX_W-1:0]   max_use;
    logic signed [MAX_W-1:0]   max_base;
    logic signed [SHIFT_W-1:0] shift;
    logic [DATA_W-1:0]         val_i;
    logic [DATA_W-1:0]         val_q;

    assign in_index  = i_s_axis_tdata[7:0];
    assign in_word   = i_s_axis_tdata[39:8];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_oor    = ({1'b0, in_index} >= (INDEX_W + 1)'(NUM_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_bits   <= TARGET_BITS_RST;
            r_cfg.autoscale_on  <= 1'b0;
            r_cfg.mantissa_bits <= MANTISSA_BITS_RST;
            r_cfg.exponent_bits <= EXPONENT_BITS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TARGET_BITS:   r_cfg.target_bits   <= i_cfg_data[4:0];
                CFG_AUTOSCALE_ON:  r_cfg.autoscale_on  <= i_cfg_data[0];
                CFG_MANTISSA_BITS: r_cfg.mantissa_bits <= i_cfg_data[3:0];
                CFG_EXPONENT_BITS: r_cfg.exponent_bits <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    csi_fwu_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept && (i_s_axis_tuser == REQ_LOAD) && !in_oor),
        .i_wr_addr (in_index[ADDR_W-1:0]),
        .i_wr_data (in_word),
        .i_rd_en   (in_accept && (i_s_axis_tuser == REQ_READ) && !in_oor),
        .i_rd_addr (in_index[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_adv          = r_s1_valid && ((r_s1_req == REQ_LOAD) || out_free);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req       <= i_s_axis_tuser;
            r_s1_oor       <= in_oor;
            r_s1_idx_zero  <= (in_index == '0);
            r_s1_load_word <= in_word;
        end
    end

    always_comb begin
        s1_word  = (r_s1_req == REQ_LOAD) ? r_s1_load_word : rd_data;
        nm       = man_width(r_cfg.mantissa_bits);
        ne       = exp_width(r_cfg.exponent_bits);
        q_lsb    = 5'(ne);
        i_lsb    = 5'(ne) + 5'(nm);
        si_pos   = 6'(ne) + 6'({nm, 1'b0}) - 6'd1;
        sign_i   = (si_pos < 6'd32) ? s1_word[si_pos[4:0]] : 1'b0;
        sign_q   = s1_word[5'(i_lsb - 5'd1)];
        mag_i    = mag_field(s1_word, i_lsb, nm);
        mag_q    = mag_field(s1_word, q_lsb, nm);
        mag_or   = mag_i | mag_q;
        exp_val  = word_exponent(s1_word, ne);
        exp_top  = exp_val + $signed({5'd0, msb_pos(mag_or)});
        half_neg = neg_half(ne);
        max_use  = r_cfg.autoscale_on ? r_max : half_neg;
        shift    = SHIFT_W'(exp_val) + $signed({5'd0, r_cfg.target_bits})
                   - SHIFT_W'(max_use);
        max_base = r_s1_idx_zero ? half_neg : r_max;
        n_max    = r_max;
        if (r_s1_valid && (r_s1_req == REQ_LOAD) && !r_s1_oor) begin
            n_max = max_base;
            if (r_cfg.autoscale_on && (mag_or != '0) && (exp_top > max_base)) begin
                n_max = exp_top;
            end
        end
    end

    csi_fwu_scale u_scale_i (
        .i_mag       (mag_i),
        .i_neg       (sign_i),
        .i_shift     (shift),
        .i_man_width (nm),
        .o_value     (val_i)
    );

    csi_fwu_scale u_scale_q (
        .i_mag       (mag_q),
        .i_neg       (sign_q),
        .i_shift     (shift),
        .i_man_width (nm),
        .o_value     (val_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= neg_half(EXPONENT_BITS_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_max <= n_max;
            if (s1_adv && (r_s1_req == REQ_READ)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && (r_s1_req == REQ_READ)) begin
            r_out_data <= r_s1_oor ? 64'd0 : {val_q, val_i};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("Accepted request did not reach the decode stage.");

    a_stalled_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_req == REQ_READ) && r_out_valid && !i_m_axis_tready)
        |-> !o_s_axis_tready)
        else $error("Request accepted while a read was held by a stalled output.");

    a_read_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_req == REQ_READ) && out_free) |=> r_out_valid)
        else $error("Decoded read did not reach the output register.");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_req == REQ_LOAD) && !r_s1_oor && r_s1_idx_zero
         && !r_cfg.autoscale_on) |=> (r_max == $past(half_neg)))
        else $error("Load at index zero did not restart the frame maximum.");
`endif

endmodule

### rtl/csi_fwu_store.sv
// Packed word store: one write port and one registered read port.
// Depends on csi_fwu_pkg for the depth and word width.
module csi_fwu_store (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [csi_fwu_pkg::ADDR_W-1:0]   i_wr_addr,
    input  logic [csi_fwu_pkg::WORD_W-1:0]   i_wr_data,
    input  logic                             i_rd_en,
    input  logic [csi_fwu_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [csi_fwu_pkg::WORD_W-1:0]   o_rd_data
);
    import csi_fwu_pkg::*;

    logic [WORD_W-1:0] r_mem [NUM_ENTRIES];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/csi_fwu_scale.sv
// Scales one mantissa magnitude by a signed shift and applies its sign.
// Depends on csi_fwu_pkg for widths.
module csi_fwu_scale (
    input  logic [csi_fwu_pkg::MAG_W-1:0]          i_mag,
    input  logic                                   i_neg,
    input  logic signed [csi_fwu_pkg::SHIFT_W-1:0] i_shift,
    input  logic [3:0]                             i_man_width,
    output logic [csi_fwu_pkg::DATA_W-1:0]         o_value
);
    import csi_fwu_pkg::*;

    logic signed [SHIFT_W-1:0] lim;
    logic signed [SHIFT_W-1:0] neg_shift;
    logic [DATA_W-1:0]         mag_ext;
    logic [DATA_W-1:0]         scaled;

    always_comb begin
        lim       = -$signed({6'd0, i_man_width});
        neg_shift = -i_shift;
        mag_ext   = DATA_W'(i_mag);
        if (i_shift < lim) begin
            scaled = '0;
        end else if (i_shift < 10'sd0) begin
            scaled = mag_ext >> neg_shift[3:0];
        end else if (i_shift < 10'sd32) begin
            scaled = mag_ext << i_shift[4:0];
        end else begin
            scaled = '0;
        end
        o_value = i_neg ? (DATA_W'(0) - scaled) : scaled;
    end

endmodule
